// ===== rtl/sd_pkg.sv =====
package sd_pkg;

    localparam int BpmW      = 10;
    localparam int StepsW    = 5;
    localparam int IntervalW = 18;
    localparam int DenW      = 14;
    localparam int TimeW     = 32;
    localparam int IdxW      = 4;
    localparam int CfgIdxW   = 1;
    localparam int CfgDataW  = 10;

    localparam int TicksPerStepDef = 6;
    localparam int MainStepsDef    = 16;

    localparam int IntervalNum   = 240000;
    localparam int TempoReset    = 120;
    localparam int StepsReset    = 16;
    localparam int StepsMax      = 16;
    localparam int IntervalReset =
        (IntervalNum + TempoReset * StepsReset - 1) / (TempoReset * StepsReset);

    // register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] CfgTempo = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgSteps = 1'b1;

    // operation codes of an input beat
    localparam logic OpTick  = 1'b0;
    localparam logic OpStart = 1'b1;

    typedef struct packed {
        logic                 busy;
        logic [StepsW-1:0]    steps;
        logic [IntervalW-1:0] interval;
    } t_tempo_cfg;

    // x mod c for small x, by shifted compare and subtract
    function automatic logic [IdxW-1:0] f_wrap_mod(input logic [StepsW-1:0] x,
                                                   input logic [StepsW-1:0] c);
        logic [StepsW+IdxW-1:0] rem;
        logic [StepsW+IdxW-1:0] div;
        rem = (StepsW+IdxW)'(x);
        for (int k = IdxW; k >= 0; k--) begin
            div = (StepsW+IdxW)'(c) << k;
            if (rem >= div) begin
                rem = rem - div;
            end
        end
        return IdxW'(rem);
    endfunction

endpackage

// ===== rtl/sd_in_if.sv =====
interface sd_in_if import sd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [TimeW-1:0] now_ms;

    modport source (output valid, operation, now_ms, input ready);
    modport sink   (input valid, operation, now_ms, output ready);
endinterface

// ===== rtl/sd_out_if.sv =====
interface sd_out_if import sd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            main_step_fired;
    logic [IdxW-1:0] main_step_index;
    logic            custom_step_fired;
    logic [IdxW-1:0] custom_step_index;

    modport source (output valid, main_step_fired, main_step_index,
                    custom_step_fired, custom_step_index, input ready);
    modport sink   (input valid, main_step_fired, main_step_index,
                    custom_step_fired, custom_step_index, output ready);
endinterface

// ===== rtl/sd_tempo.sv =====
module sd_tempo import sd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output t_tempo_cfg          o_cfg
);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StLoad = 2'd1;
    localparam logic [1:0] StDiv  = 2'd2;
    localparam logic [1:0] StDone = 2'd3;
    localparam int         CntW   = $clog2(IntervalW);

    logic [BpmW-1:0]      r_bpm,      n_bpm;
    logic [StepsW-1:0]    r_steps,    n_steps;
    logic [IntervalW-1:0] r_interval, n_interval;
    logic [1:0]           r_state,    n_state;
    logic [CntW-1:0]      r_cnt,      n_cnt;
    logic [DenW-1:0]      r_den,      n_den;
    logic [DenW-1:0]      r_rem,      n_rem;
    logic [IntervalW-1:0] r_quo,      n_quo;

    logic [BpmW-1:0]   bpm_eff;
    logic [StepsW-1:0] steps_wr;
    logic [DenW:0]     trial;

    assign bpm_eff = (r_bpm == '0) ? BpmW'(1) : r_bpm;
    assign trial   = {r_rem, r_quo[IntervalW-1]};

    always_comb begin
        steps_wr = i_cfg_data[StepsW-1:0];
        if (steps_wr == '0) begin
            steps_wr = StepsW'(1);
        end else if (steps_wr > StepsW'(StepsMax)) begin
            steps_wr = StepsW'(StepsMax);
        end
    end

    always_comb begin
        n_bpm      = r_bpm;
        n_steps    = r_steps;
        n_interval = r_interval;
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_den      = r_den;
        n_rem      = r_rem;
        n_quo      = r_quo;

        case (r_state)
            StLoad: begin
                n_den   = DenW'(bpm_eff) * DenW'(r_steps);
                n_rem   = '0;
                n_quo   = IntervalW'(IntervalNum);
                n_cnt   = '0;
                n_state = StDiv;
            end
            StDiv: begin
                // restoring division, one quotient bit a cycle
                if (trial >= {1'b0, r_den}) begin
                    n_rem = DenW'(trial - {1'b0, r_den});
                    n_quo = {r_quo[IntervalW-2:0], 1'b1};
                end else begin
                    n_rem = trial[DenW-1:0];
                    n_quo = {r_quo[IntervalW-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CntW'(IntervalW - 1)) begin
                    n_state = StDone;
                end
            end
            StDone: begin
                // round up when the division leaves a remainder
                n_interval = r_quo + IntervalW'(r_rem != '0);
                n_state    = StIdle;
            end
            default: begin
                n_state = StIdle;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_index)
                CfgTempo: begin
                    n_bpm   = i_cfg_data[BpmW-1:0];
                    n_state = StLoad;
                end
                CfgSteps: begin
                    n_steps = steps_wr;
                    n_state = StLoad;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpm      <= BpmW'(TempoReset);
            r_steps    <= StepsW'(StepsReset);
            r_interval <= IntervalW'(IntervalReset);
            r_state    <= StIdle;
            r_cnt      <= '0;
        end else begin
            r_bpm      <= n_bpm;
            r_steps    <= n_steps;
            r_interval <= n_interval;
            r_state    <= n_state;
            r_cnt      <= n_cnt;
        end
        r_den <= n_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_cfg.busy     = (r_state != StIdle);
    assign o_cfg.steps    = r_steps;
    assign o_cfg.interval = r_interval;

endmodule

// ===== rtl/sd_step.sv =====
module sd_step import sd_pkg::*; #(
    parameter int TICKS_PER_STEP = TicksPerStepDef,
    parameter int MAIN_STEPS     = MainStepsDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_tempo_cfg i_cfg,
    input  logic       i_cfg_we,
    sd_in_if.sink      i_in,
    sd_out_if.source   o_out
);

    localparam int PreW  = $clog2(TICKS_PER_STEP + 1);
    localparam int MainW = $clog2(MAIN_STEPS);

    logic             r_in_valid;
    logic             r_in_op;
    logic [TimeW-1:0] r_in_now;

    logic [PreW-1:0]  r_pre,   n_pre;
    logic [MainW-1:0] r_main,  n_main;
    logic [TimeW-1:0] r_last,  n_last;
    logic [IdxW-1:0]  r_cidx,  n_cidx;

    logic             r_out_valid;
    logic             r_out_mfire;
    logic [IdxW-1:0]  r_out_midx;
    logic             r_out_cfire;
    logic [IdxW-1:0]  r_out_cidx;

    logic             accept;
    logic             advance;
    logic             main_fire;
    logic             cust_fire;
    logic [TimeW-1:0] elapsed;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    // hold off new beats while the interval is being recomputed
    assign i_in.ready = (!r_in_valid || advance) && !i_cfg.busy && !i_cfg_we;
    assign accept     = i_in.valid && i_in.ready;
    assign elapsed    = r_in_now - r_last;

    always_comb begin
        n_pre     = r_pre;
        n_main    = r_main;
        n_last    = r_last;
        n_cidx    = r_cidx;
        main_fire = 1'b0;
        cust_fire = 1'b0;
        if (advance) begin
            if (r_in_op == OpStart) begin
                n_last = r_in_now;
                n_cidx = '0;
            end else begin
                if (r_pre == PreW'(TICKS_PER_STEP - 1)) begin
                    n_pre     = '0;
                    n_main    = (r_main == MainW'(MAIN_STEPS - 1)) ? '0 : r_main + 1'b1;
                    main_fire = 1'b1;
                end else begin
                    n_pre = r_pre + 1'b1;
                end
                if (elapsed >= TimeW'(i_cfg.interval)) begin
                    n_last    = r_in_now;
                    // index may be stale after the step count shrank
                    n_cidx    = f_wrap_mod(StepsW'({1'b0, r_cidx}) + 1'b1, i_cfg.steps);
                    cust_fire = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pre       <= '0;
            r_main      <= '0;
            r_last      <= '0;
            r_cidx      <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_pre  <= n_pre;
            r_main <= n_main;
            r_last <= n_last;
            r_cidx <= n_cidx;
        end
        if (accept) begin
            r_in_op  <= i_in.operation;
            r_in_now <= i_in.now_ms;
        end
        if (advance) begin
            r_out_mfire <= main_fire;
            r_out_midx  <= IdxW'(n_main);
            r_out_cfire <= cust_fire;
            r_out_cidx  <= n_cidx;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.main_step_fired   = r_out_mfire;
    assign o_out.main_step_index   = r_out_midx;
    assign o_out.custom_step_fired = r_out_cfire;
    assign o_out.custom_step_index = r_out_cidx;

endmodule

// ===== rtl/step_sequencer_clock_divider.sv =====
// Step sequencer clock divider: every input beat is a clock tick or a start event with a
// millisecond timestamp, and yields exactly one result beat. Ticks drive a prescaler of
// TICKS_PER_STEP that advances the main step index modulo MAIN_STEPS; a custom step index
// advances modulo the step count once ceil(240000 / (bpm * steps)) ms have passed since its
// last step. One beat is taken every clock cycle while the output takes results and the
// interval is not being recomputed; beats pass an input and an output register, and a
// stalled output holds the input register and so stops further beats. A write to either
// register restarts a bit-serial divider for the interval; the input is held off in the
// write cycle and while the divider loads, yields 18 quotient bits one a cycle and rounds.
module step_sequencer_clock_divider import sd_pkg::*; #(
    parameter int TICKS_PER_STEP = TicksPerStepDef,
    parameter int MAIN_STEPS     = MainStepsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    sd_in_if.sink               i_in,
    sd_out_if.source            o_out
);

    t_tempo_cfg tempo_cfg;

    sd_tempo u_tempo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (tempo_cfg)
    );

    sd_step #(
        .TICKS_PER_STEP (TICKS_PER_STEP),
        .MAIN_STEPS     (MAIN_STEPS)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (tempo_cfg),
        .i_cfg_we (i_cfg_we),
        .i_in     (i_in),
        .o_out    (o_out)
    );

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sd_pkg::*;

    localparam int IDLE_PCT       = 17;
    localparam int PHASE_BEATS    = 120;
    localparam int NUM_PHASES     = 12;
    localparam int HOLD_CYCLES    = 150;
    localparam int CFG_SETTLE     = 26;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic             operation;
        logic [TimeW-1:0] now_ms;
    } t_tick_beat;

    typedef struct packed {
        logic            main_fired;
        logic [IdxW-1:0] main_idx;
        logic            custom_fired;
        logic [IdxW-1:0] custom_idx;
    } t_step_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;

    sd_in_if  in_ch ();
    sd_out_if out_ch ();

    step_sequencer_clock_divider uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // sequencer state as the testbench sees it
    logic [BpmW-1:0]      tempo_reg;
    logic [StepsW-1:0]    steps_reg;
    logic [IntervalW-1:0] interval_ms;
    int                   prescale;
    int                   main_idx;
    int                   custom_idx;
    logic [TimeW-1:0]     last_step_ms;

    t_tick_beat   pending_beats[$];
    t_step_result expected_steps[$];

    // mirror of the custom step time, used to aim ticks at the interval boundary
    logic [TimeW-1:0] gen_last;
    logic [TimeW-1:0] gen_now;

    int beats_queued;
    int beats_in;
    int results_out;
    int failures;
    int stall_cycles;
    int tick_count;
    int start_count;
    int main_fires;
    int custom_fires;
    int settings_used;
    int hold_left;
    bit hold_done;
    bit in_taken;
    logic calm;

    assign calm = (beats_in >= 700) && (beats_in < 950);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [IntervalW-1:0] interval_for(input logic [BpmW-1:0] bpm,
                                                           input logic [StepsW-1:0] steps);
        int unsigned b;
        int unsigned den;
        b   = (bpm == '0) ? 1 : int'(bpm);
        den = b * int'(steps);
        return IntervalW'((IntervalNum + den - 1) / den);
    endfunction

    function automatic t_step_result advance_sequencer(input logic op,
                                                       input logic [TimeW-1:0] now);
        t_step_result r;
        logic [TimeW-1:0] elapsed;
        r = '0;
        if (op == OpStart) begin
            last_step_ms = now;
            custom_idx   = 0;
            start_count++;
        end else begin
            tick_count++;
            if (prescale == TicksPerStepDef - 1) begin
                prescale     = 0;
                main_idx     = (main_idx + 1) % MainStepsDef;
                r.main_fired = 1'b1;
                main_fires++;
            end else begin
                prescale++;
            end
            elapsed = now - last_step_ms;
            if (elapsed >= TimeW'(interval_ms)) begin
                last_step_ms   = now;
                custom_idx     = (custom_idx + 1) % int'(steps_reg);
                r.custom_fired = 1'b1;
                custom_fires++;
            end
        end
        r.main_idx   = IdxW'(main_idx);
        r.custom_idx = IdxW'(custom_idx);
        return r;
    endfunction

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        logic [StepsW-1:0] s;
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == CfgTempo) begin
            tempo_reg = data[BpmW-1:0];
        end else begin
            s = data[StepsW-1:0];
            if (s == '0) s = StepsW'(1);
            if (s > StepsMax) s = StepsW'(StepsMax);
            steps_reg = s;
        end
        interval_ms = interval_for(tempo_reg, steps_reg);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        // the divider holds the input off while it works
        repeat (CFG_SETTLE) @(negedge i_clk);
    endtask

    task automatic queue_beat(input logic op, input logic [TimeW-1:0] now);
        t_tick_beat b;
        b.operation = op;
        b.now_ms    = now;
        pending_beats.push_back(b);
        beats_queued++;
        gen_now = now;
        if (op == OpStart) begin
            gen_last = now;
        end else if (TimeW'(now - gen_last) >= TimeW'(interval_ms)) begin
            gen_last = now;
        end
    endtask

    task automatic random_run(input int count);
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                queue_beat(OpStart, $urandom);
            end else if (pick < 8) begin
                queue_beat(OpStart, gen_now + $urandom_range(0, interval_ms));
            end else if (pick < 13) begin
                queue_beat(OpTick, $urandom);
            end else if (pick < 35) begin
                // just short of, on, or just past the custom interval
                queue_beat(OpTick, gen_last + interval_ms - 1 + $urandom_range(0, 2));
            end else begin
                queue_beat(OpTick, gen_now + $urandom_range(0, interval_ms / 2));
            end
        end
    endtask

    task automatic wait_drained();
        while (beats_in != beats_queued || expected_steps.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // sender
    always @(negedge i_clk) begin
        t_tick_beat b;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                b = pending_beats.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.operation <= b.operation;
                in_ch.now_ms    <= b.now_ms;
            end else begin
                in_ch.valid     <= 1'b0;
                in_ch.operation <= 1'($urandom);
                in_ch.now_ms    <= $urandom;
            end
        end
    end

    // receiver, with one long hold-off once over 400 beats are in and more than 20 still queued
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!hold_done && beats_in > 400 && pending_beats.size() > 20) begin
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // checker and watchdog
    always @(posedge i_clk) begin
        t_step_result got;
        t_step_result want;
        if (!i_rst_n) begin
            in_taken     <= 1'b0;
            stall_cycles <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.main_fired   = out_ch.main_step_fired;
                got.main_idx     = out_ch.main_step_index;
                got.custom_fired = out_ch.custom_step_fired;
                got.custom_idx   = out_ch.custom_step_index;
                results_out++;
                if (expected_steps.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("result %0d with none expected: main %b/%0d custom %b/%0d",
                                 results_out, got.main_fired, got.main_idx,
                                 got.custom_fired, got.custom_idx);
                end else begin
                    want = expected_steps.pop_front();
                    if (got !== want) begin
                        failures++;
                        if (failures <= MAX_REPORTS) begin
                            $write("result %0d mismatch: main %b/%0d custom %b/%0d, ",
                                   results_out, got.main_fired, got.main_idx,
                                   got.custom_fired, got.custom_idx);
                            $display("expected main %b/%0d custom %b/%0d",
                                     want.main_fired, want.main_idx,
                                     want.custom_fired, want.custom_idx);
                        end
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_steps.push_back(advance_sequencer(in_ch.operation, in_ch.now_ms));
                beats_in <= beats_in + 1;
            end
            in_taken <= in_ch.valid && in_ch.ready;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", stall_cycles);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CfgTempo;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.operation = OpTick;
        in_ch.now_ms    = '0;
        out_ch.ready    = 1'b0;
        tempo_reg       = BpmW'(TempoReset);
        steps_reg       = StepsW'(StepsReset);
        interval_ms     = interval_for(tempo_reg, steps_reg);
        prescale        = 0;
        main_idx        = 0;
        custom_idx      = 0;
        last_step_ms    = '0;
        gen_last        = '0;
        gen_now         = '0;
        beats_queued    = 0;
        beats_in        = 0;
        results_out     = 0;
        failures        = 0;
        tick_count      = 0;
        start_count     = 0;
        main_fires      = 0;
        custom_fires    = 0;
        settings_used   = 1;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset tempo: interval of 125 ms, prescaler fires on the sixth tick
        queue_beat(OpTick, 32'd0);
        queue_beat(OpTick, 32'd124);
        queue_beat(OpTick, 32'd125);
        queue_beat(OpTick, 32'd130);
        queue_beat(OpTick, 32'd140);
        queue_beat(OpTick, 32'd150);
        queue_beat(OpStart, 32'd200);
        queue_beat(OpTick, 32'd324);
        queue_beat(OpTick, 32'd325);
        // elapsed time across the wrap of the timestamp
        queue_beat(OpStart, 32'hFFFF_FFC0);
        queue_beat(OpTick, 32'h0000_003C);
        queue_beat(OpTick, 32'h0000_003D);
        queue_beat(OpTick, 32'hFFFF_FFFF);
        queue_beat(OpTick, 32'h0000_0000);
        queue_beat(OpStart, 32'hFFFF_FFFF);
        queue_beat(OpStart, 32'h0000_0000);
        queue_beat(OpTick, 32'h0000_007D);
        random_run(PHASE_BEATS);
        wait_drained();

        for (int phase = 1; phase < NUM_PHASES; phase++) begin
            case (phase)
                1: begin
                    // zero tempo and a single step: longest interval
                    write_reg(CfgTempo, 10'd0);
                    write_reg(CfgSteps, 10'd1);
                end
                2: begin
                    write_reg(CfgTempo, 10'd1023);
                    write_reg(CfgSteps, 10'd16);
                end
                3: begin
                    write_reg(CfgTempo, 10'd1000);
                    write_reg(CfgSteps, 10'd31);
                end
                4: begin
                    // count drops to one, leaving a stale custom index
                    write_reg(CfgSteps, 10'd0);
                end
                5: begin
                    write_reg(CfgTempo, 10'd1001);
                    write_reg(CfgSteps, 10'h3E3);
                end
                6: begin
                    write_reg(CfgTempo, 10'd1);
                    write_reg(CfgSteps, 10'd17);
                end
                default: begin
                    write_reg(CfgSteps, CfgDataW'($urandom_range(0, 1023)));
                    write_reg(CfgTempo, CfgDataW'($urandom_range(0, 1023)));
                end
            endcase
            settings_used++;
            if ($urandom_range(1) == 1)
                queue_beat(OpStart, 32'hFFFF_FFFF - $urandom_range(0, 8 * interval_ms));
            else
                queue_beat(OpStart, $urandom);
            random_run(PHASE_BEATS);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        $display("ran %0d ticks and %0d starts over %0d tempo and step count settings",
                 tick_count, start_count, settings_used);
        $display("main index advanced %0d times, custom index %0d times, %0d results checked",
                 main_fires, custom_fires, results_out);
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", failures);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== step_sequencer_clock_divider.f =====
rtl/sd_pkg.sv
rtl/sd_in_if.sv
rtl/sd_out_if.sv
rtl/sd_tempo.sv
rtl/sd_step.sv
rtl/step_sequencer_clock_divider.sv
sim/tb.sv
